### rtl/swmr_pkg.sv
// shared types, constants and codes for the sliding window mean and rms block
package swmr_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int PIXELS_MAX_DEF = 256;
    localparam int WINDOW_MAX_DEF = 128;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int WIN_W     = 8;
    localparam int PIXC_W    = 9;
    localparam int WIN_LEN_RST = 100;
    localparam int PIX_CNT_RST = 256;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 2'd1;

    localparam int MEAN_W   = 24;
    localparam int RMS_W    = 24;
    localparam int STEP_W   = 7;
    localparam int MEAN_POS_MAX = 8388607;
    localparam int MEAN_NEG_MAX = 8388608;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_valid;
    } swmr_item_t;

    typedef struct packed {
        logic signed [MEAN_W-1:0] pixel_mean;
        logic [RMS_W-1:0]         pixel_rms;
        logic                     last_pixel;
    } swmr_result_t;

    typedef enum logic [1:0] {
        OP_DIV  = 2'b01,
        OP_SQRT = 2'b10
    } swmr_op_t;

    typedef struct packed {
        logic              start;
        swmr_op_t          op;
        logic [STEP_W-1:0] steps;
    } swmr_cmd_t;

endpackage

### rtl/sliding_window_mean_rms.sv
// top level: per-pixel sliding window mean and rms deviation with sequencer
//
// Frames arrive as a stream of samples in pixel order, one transaction per
// pixel. Every sample replaces the oldest entry of its pixel's ring of
// window_len samples and yields one result transaction: the window mean and
// the population rms deviation, both with 8 fraction bits, plus a flag on
// the last pixel of the frame. Invalid samples enter the window as zero, and
// the history starts cleared, so zeros count until the window has filled.
// After reset a clearing pass zeroes the history and the sums, one entry a
// cycle, over all PIXELS_MAX*WINDOW_MAX history entries; item_stall is
// high for that time, configuration writes are taken throughout. Each sample
// then goes through memory read, squaring, update and multiply, and then one
// shared bit-serial unit runs the mean division, the variance division and
// the square root in turn, one bit per cycle. A finished result sits in an
// output register, so the next sample is taken while it waits. Write
// configuration only while idle.
module sliding_window_mean_rms #(
    parameter int PIXELS_MAX = swmr_pkg::PIXELS_MAX_DEF,
    parameter int WINDOW_MAX = swmr_pkg::WINDOW_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [swmr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swmr_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  swmr_pkg::swmr_item_t              item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output swmr_pkg::swmr_result_t            result
);
    import swmr_pkg::*;

    // widths
    localparam int PB     = (PIXELS_MAX > 1) ? $clog2(PIXELS_MAX) : 1;
    localparam int WB     = $clog2(WINDOW_MAX);
    localparam int HDEPTH = PIXELS_MAX * WINDOW_MAX;
    localparam int HA_W   = $clog2(HDEPTH);
    localparam int NW     = WIN_W;
    localparam int SUM_W  = SAMPLE_BITS + WB + 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS + WB;
    localparam int PSQ_W  = 2 * SAMPLE_BITS;
    localparam int PA_W   = NW + SQ_W;
    localparam int PB_W   = 2 * SUM_W;
    localparam int NUM_W  = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
    localparam int ACC_W  = ((NUM_W + 16) / 2) * 2;
    localparam int MW     = SUM_W + 8;
    localparam int DV_W   = 2 * NW;
    localparam int CMPW   = (PB + 1 > PIXC_W + 1) ? PB + 1 : PIXC_W + 1;
    localparam int SCW    = (WB + 1 > NW + 1) ? WB + 1 : NW + 1;

    // sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_SQR   = 9'b000000100,
        ST_UPD   = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_MEAN  = 9'b000100000,
        ST_VAR   = 9'b001000000,
        ST_SQRT  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // control state
    logic [HA_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [WIN_W-1:0]  win_len_reg, win_len_next;
    logic [PIXC_W-1:0] pix_cnt_reg, pix_cnt_next;
    logic [PB-1:0]     pos_reg, pos_next;
    logic [WB-1:0]     slot_reg, slot_next;
    logic              res_valid_reg, res_valid_next;

    // per-transaction payload
    logic signed [SAMPLE_BITS-1:0] v_reg;
    logic [PB-1:0]                 pix_reg;
    logic [WB-1:0]                 islot_reg;
    logic [NW-1:0]                 n_reg;
    logic                          last_reg;
    logic [PSQ_W-1:0]              vsq_reg;
    logic [PSQ_W-1:0]              osq_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]               sq_reg;
    logic [PA_W-1:0]               prod_a_reg;
    logic [PB_W-1:0]               prod_b_reg;
    logic signed [MEAN_W-1:0]      mean_reg;
    logic [RMS_W-1:0]              rms_reg;
    swmr_result_t                  result_reg;

    // memory side
    logic signed [SAMPLE_BITS-1:0] rd_sample;
    logic signed [SUM_W-1:0]       rd_sum;
    logic [SQ_W-1:0]               rd_sq;
    logic [SQ_W-1:0]               sq_new;

    // shared unit side
    swmr_cmd_t         cmd;
    logic [ACC_W-1:0]  acc_init;
    logic [DV_W-1:0]   divisor;
    logic              unit_done;
    logic [ACC_W-1:0]  quo;

    // effective register values, clamped to the legal range
    logic [SCW-1:0]    n_wide;
    logic [NW-1:0]     n_cur;
    logic [CMPW-1:0]   pc_wide;
    logic [WB-1:0]     slot_cur;
    logic [SCW-1:0]    slot_inc;
    logic              last_cur;
    logic              item_acc;
    logic              out_load;

    // mean and variance helpers
    logic                     sum_neg;
    logic [SUM_W-1:0]         sum_mag;
    logic [MW-1:0]            qm;
    logic signed [MEAN_W-1:0] mean_sat;
    logic signed [NUM_W-1:0]  num;
    logic [NUM_W-2:0]         num_pos;

    assign item_acc   = item_valid && !item_stall;
    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        if (win_len_reg == '0)
            n_wide = SCW'(1);
        else if (SCW'(win_len_reg) > SCW'(WINDOW_MAX))
            n_wide = SCW'(WINDOW_MAX);
        else
            n_wide = SCW'(win_len_reg);
        n_cur = n_wide[NW-1:0];

        if (pix_cnt_reg == '0)
            pc_wide = CMPW'(1);
        else if (CMPW'(pix_cnt_reg) > CMPW'(PIXELS_MAX))
            pc_wide = CMPW'(PIXELS_MAX);
        else
            pc_wide = CMPW'(pix_cnt_reg);

        // slot left over from a longer window wraps to the start
        slot_cur = (SCW'(slot_reg) >= n_wide) ? '0 : slot_reg;
        slot_inc = SCW'(slot_cur) + SCW'(1);
        last_cur = (CMPW'(pos_reg) + CMPW'(1) >= pc_wide);
    end

    // configuration writes and frame position
    always_comb
    begin
        win_len_next = win_len_reg;
        pix_cnt_next = pix_cnt_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_WINDOW_LEN:  win_len_next = cfg_data[WIN_W-1:0];
                REG_PIXEL_COUNT: pix_cnt_next = cfg_data[PIXC_W-1:0];
                default:         ;
            endcase
        end

        pos_next  = pos_reg;
        slot_next = slot_reg;
        if (item_acc)
        begin
            if (last_cur)
            begin
                pos_next  = '0;
                slot_next = (slot_inc >= n_wide) ? '0 : slot_inc[WB-1:0];
            end
            else
            begin
                pos_next  = pos_reg + PB'(1);
                slot_next = slot_cur;
            end
        end
    end

    // mean: |sum|*256 / n through the shared unit, sign restored afterwards
    assign sum_neg = sum_reg[SUM_W-1];
    assign sum_mag = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign qm      = quo[MW-1:0];

    always_comb
    begin
        if (sum_neg)
        begin
            if (qm > MW'(MEAN_NEG_MAX))
                mean_sat = MEAN_W'(-MEAN_NEG_MAX);
            else
                mean_sat = MEAN_W'(-qm);
        end
        else
        begin
            if (qm > MW'(MEAN_POS_MAX))
                mean_sat = MEAN_W'(MEAN_POS_MAX);
            else
                mean_sat = MEAN_W'(qm);
        end
    end

    // variance numerator n*sumsq - sum^2, clamped at zero
    assign num     = $signed(NUM_W'(prod_a_reg)) - $signed(NUM_W'(prod_b_reg));
    assign num_pos = num[NUM_W-1] ? '0 : num[NUM_W-2:0];

    // shared unit commands
    always_comb
    begin
        cmd.start = 1'b0;
        cmd.op    = OP_DIV;
        cmd.steps = STEP_W'(MW);
        acc_init  = ACC_W'({sum_mag, 8'h00}) << (ACC_W - MW);
        divisor   = DV_W'(n_reg);
        unique case (state_reg)
            ST_MUL:
            begin
                cmd.start = 1'b1;
            end
            ST_MEAN:
            begin
                cmd.start = unit_done;
                cmd.steps = STEP_W'(ACC_W);
                acc_init  = ACC_W'(num_pos) << 16;
                divisor   = DV_W'(n_reg) * DV_W'(n_reg);
            end
            ST_VAR:
            begin
                cmd.start = unit_done;
                cmd.op    = OP_SQRT;
                cmd.steps = STEP_W'(ACC_W / 2);
                acc_init  = quo;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + HA_W'(1);
                if (clr_cnt_reg == HA_W'(HDEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_SQR;
            end
            ST_SQR:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_MEAN;
            ST_MEAN:
            begin
                if (unit_done)
                    state_next = ST_VAR;
            end
            ST_VAR:
            begin
                if (unit_done)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (unit_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !result_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    assign out_load = (state_reg == ST_DONE) && (!res_valid_reg || !result_stall);
    assign sq_new   = rd_sq + SQ_W'(vsq_reg) - SQ_W'(osq_reg);

    always_comb
    begin
        if (out_load)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !result_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            win_len_reg   <= WIN_W'(WIN_LEN_RST);
            pix_cnt_reg   <= PIXC_W'(PIX_CNT_RST);
            pos_reg       <= '0;
            slot_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            win_len_reg   <= win_len_next;
            pix_cnt_reg   <= pix_cnt_next;
            pos_reg       <= pos_next;
            slot_reg      <= slot_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            v_reg     <= item.sample_valid ? item.sample : '0;
            pix_reg   <= pos_reg;
            islot_reg <= slot_cur;
            n_reg     <= n_cur;
            last_reg  <= last_cur;
        end
        if (state_reg == ST_SQR)
        begin
            vsq_reg <= PSQ_W'(v_reg * v_reg);
            osq_reg <= PSQ_W'(rd_sample * rd_sample);
            sum_reg <= rd_sum + SUM_W'(v_reg) - SUM_W'(rd_sample);
        end
        if (state_reg == ST_UPD)
            sq_reg <= sq_new;
        if (state_reg == ST_MUL)
        begin
            prod_a_reg <= PA_W'(n_reg) * PA_W'(sq_reg);
            prod_b_reg <= PB_W'(sum_reg * sum_reg);
        end
        if (state_reg == ST_MEAN && unit_done)
            mean_reg <= mean_sat;
        if (state_reg == ST_SQRT && unit_done)
            rms_reg <= (quo[ACC_W-1:RMS_W] != '0) ? '1 : quo[RMS_W-1:0];
        if (out_load)
        begin
            result_reg.pixel_mean <= mean_reg;
            result_reg.pixel_rms  <= rms_reg;
            result_reg.last_pixel <= last_reg;
        end
    end

    swmr_store #(
        .PIXELS_MAX (PIXELS_MAX),
        .WINDOW_MAX (WINDOW_MAX),
        .SUM_W      (SUM_W),
        .SQ_W       (SQ_W)
    ) u_store (
        .clk       (clk),
        .rd_en     (item_acc),
        .rd_pix    (pos_reg),
        .rd_slot   (slot_cur),
        .wr_en     (state_reg == ST_UPD),
        .wr_pix    (pix_reg),
        .wr_slot   (islot_reg),
        .wr_sample (v_reg),
        .wr_sum    (sum_reg),
        .wr_sq     (sq_new),
        .clr_en    (state_reg == ST_CLEAR),
        .clr_addr  (clr_cnt_reg),
        .rd_sample (rd_sample),
        .rd_sum    (rd_sum),
        .rd_sq     (rd_sq)
    );

    swmr_unit #(
        .ACC_W (ACC_W),
        .DV_W  (DV_W)
    ) u_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .acc_init (acc_init),
        .divisor  (divisor),
        .done     (unit_done),
        .quo      (quo)
    );

    assign result_valid = res_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/swmr_unit.sv
// shared bit-serial divide and square root unit
module swmr_unit #(
    parameter int ACC_W = 64,
    parameter int DV_W  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swmr_pkg::swmr_cmd_t    cmd,
    input  logic [ACC_W-1:0]       acc_init,
    input  logic [DV_W-1:0]        divisor,
    output logic                   done,
    output logic [ACC_W-1:0]       quo
);
    import swmr_pkg::*;

    localparam int REM_A = ACC_W / 2 + 3;
    localparam int REM_B = DV_W + 2;
    localparam int REM_W = (REM_A > REM_B) ? REM_A : REM_B;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    swmr_op_t          op_reg, op_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ACC_W-1:0]  quo_reg, quo_next;
    logic [DV_W-1:0]   dv_reg, dv_next;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [ACC_W-1:0]  acc_sh;
    logic              ge;

    // one quotient or root bit per cycle
    always_comb
    begin
        unique case (op_reg)
            OP_SQRT:
            begin
                rem_sh = {rem_reg[REM_W-3:0], acc_reg[ACC_W-1 -: 2]};
                trial  = REM_W'({quo_reg[ACC_W/2-1:0], 2'b01});
                acc_sh = acc_reg << 2;
            end
            default:
            begin
                rem_sh = {rem_reg[REM_W-2:0], acc_reg[ACC_W-1]};
                trial  = REM_W'(dv_reg);
                acc_sh = acc_reg << 1;
            end
        endcase
        ge = (rem_sh >= trial);
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dv_next   = dv_reg;
        if (cmd.start)
        begin
            run_next = 1'b1;
            op_next  = cmd.op;
            cnt_next = cmd.steps;
            acc_next = acc_init;
            rem_next = '0;
            quo_next = '0;
            dv_next  = divisor;
        end
        else if (run_reg)
        begin
            acc_next = acc_sh;
            rem_next = ge ? (rem_sh - trial) : rem_sh;
            quo_next = {quo_reg[ACC_W-2:0], ge};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dv_reg  <= dv_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### rtl/swmr_store.sv
// sample history and per-pixel running sum memories
module swmr_store #(
    parameter int PIXELS_MAX = 256,
    parameter int WINDOW_MAX = 128,
    parameter int SUM_W      = 24,
    parameter int SQ_W       = 39
) (
    input  logic                                         clk,
    input  logic                                         rd_en,
    input  logic [((PIXELS_MAX > 1) ? $clog2(PIXELS_MAX) : 1)-1:0] rd_pix,
    input  logic [$clog2(WINDOW_MAX)-1:0]                rd_slot,
    input  logic                                         wr_en,
    input  logic [((PIXELS_MAX > 1) ? $clog2(PIXELS_MAX) : 1)-1:0] wr_pix,
    input  logic [$clog2(WINDOW_MAX)-1:0]                wr_slot,
    input  logic signed [swmr_pkg::SAMPLE_BITS-1:0]      wr_sample,
    input  logic signed [SUM_W-1:0]                      wr_sum,
    input  logic [SQ_W-1:0]                              wr_sq,
    input  logic                                         clr_en,
    input  logic [$clog2(PIXELS_MAX*WINDOW_MAX)-1:0]     clr_addr,
    output logic signed [swmr_pkg::SAMPLE_BITS-1:0]      rd_sample,
    output logic signed [SUM_W-1:0]                      rd_sum,
    output logic [SQ_W-1:0]                              rd_sq
);
    import swmr_pkg::*;

    localparam int PB     = (PIXELS_MAX > 1) ? $clog2(PIXELS_MAX) : 1;
    localparam int HDEPTH = PIXELS_MAX * WINDOW_MAX;
    localparam int HA_W   = $clog2(HDEPTH);

    logic signed [SAMPLE_BITS-1:0] hist_mem [HDEPTH];
    logic signed [SUM_W-1:0]       sum_mem  [PIXELS_MAX];
    logic [SQ_W-1:0]               sq_mem   [PIXELS_MAX];

    logic [HA_W-1:0] rd_addr;
    logic [HA_W-1:0] wr_addr;
    logic [HA_W-1:0] h_addr;
    logic            clr_pix;

    assign rd_addr = HA_W'(rd_pix) * HA_W'(WINDOW_MAX) + HA_W'(rd_slot);
    assign wr_addr = HA_W'(wr_pix) * HA_W'(WINDOW_MAX) + HA_W'(wr_slot);
    assign h_addr  = clr_en ? clr_addr : wr_addr;
    assign clr_pix = clr_en && (clr_addr < HA_W'(PIXELS_MAX));

    always_ff @(posedge clk)
    begin
        if (clr_en || wr_en)
            hist_mem[h_addr] <= clr_en ? '0 : wr_sample;
        if (rd_en)
            rd_sample <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (clr_pix)
        begin
            sum_mem[clr_addr[PB-1:0]] <= '0;
            sq_mem[clr_addr[PB-1:0]]  <= '0;
        end
        else if (wr_en)
        begin
            sum_mem[wr_pix] <= wr_sum;
            sq_mem[wr_pix]  <= wr_sq;
        end
        if (rd_en)
        begin
            rd_sum <= sum_mem[rd_pix];
            rd_sq  <= sq_mem[rd_pix];
        end
    end

endmodule

### rtl/swmr_checker.sv
// port-level checker for the sliding window block, with its bind
module swmr_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_stall,
    input logic                   result_valid,
    input logic                   result_stall,
    input swmr_pkg::swmr_result_t result
);
    import swmr_pkg::*;

    // a held result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // a held result does not change
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    // one sample at a time: item_stall is held high after a transaction is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall ##1 item_stall ##1 item_stall)
        else $error("sample taken while previous one is in progress");

    // clearing pass holds off samples right after reset
    a_clear: assert property (@(posedge clk)
        $rose(rst_n) |-> item_stall && !result_valid)
        else $error("block ready before clearing pass");

endmodule

bind sliding_window_mean_rms swmr_checker u_swmr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
